FILE: design/fsip_pkg.sv
package fsip_pkg;

  localparam int CharW     = 8;
  localparam int ArgW      = 64;
  localparam int WordW     = 32;
  localparam int NibW      = 4;
  localparam int NibCnt    = ArgW / NibW;
  localparam int NleftW    = $clog2(NibCnt + 1);
  localparam int DecDigits = 10;
  localparam int BcdW      = DecDigits * NibW;
  localparam int OctDigits = (WordW + 2) / 3;
  localparam int StepW     = $clog2(WordW);

  localparam logic [CharW-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CharW-1:0] CHAR_PCT   = 8'h25;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CHAR_0     = 8'h30;
  localparam logic [CharW-1:0] CHAR_A_LC  = 8'h61;
  localparam logic [CharW-1:0] CHAR_C_LC  = 8'h63;
  localparam logic [CharW-1:0] CHAR_D_LC  = 8'h64;
  localparam logic [CharW-1:0] CHAR_O_LC  = 8'h6f;
  localparam logic [CharW-1:0] CHAR_P_LC  = 8'h70;
  localparam logic [CharW-1:0] CHAR_U_LC  = 8'h75;
  localparam logic [CharW-1:0] CHAR_X_LC  = 8'h78;

  typedef enum logic [3:0] {
    K_NUL, K_PCT, K_C, K_D, K_O, K_U, K_X, K_P, K_OTHER
  } kind_t;

  typedef enum logic [2:0] {
    SEL_CH, SEL_ARG, SEL_MINUS, SEL_ZERO, SEL_X, SEL_DIGIT
  } out_sel_t;

  typedef enum logic [1:0] {
    LD_HEX64, LD_HEX32, LD_OCT, LD_BCD
  } nib_src_t;

  typedef struct packed {
    logic     load_item;
    logic     dec_start;
    logic     dec_step;
    logic     nib_load;
    nib_src_t nib_src;
    logic     shift;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  neg;
    logic  top_zero;
    logic  nleft_one;
    logic  dec_done;
  } sts_t;

  function automatic logic [CharW-1:0] digit_char(input logic [NibW-1:0] d);
    logic [CharW-1:0] res;
    if (d < 4'd10) begin
      res = CHAR_0 + {4'b0, d};
    end else begin
      res = CHAR_A_LC + {4'b0, d} - 8'd10;
    end
    return res;
  endfunction

endpackage

FILE: design/fsip_in_if.sv
interface fsip_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fmt_char;
  logic [63:0] arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink (input valid, input fmt_char, input arg_value, output ready);
endinterface

FILE: design/fsip_out_if.sv
interface fsip_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

FILE: design/fsip_dp.sv
module fsip_dp (
  input  logic                              clk,
  input  logic [fsip_pkg::CharW-1:0]        in_fmt_char,
  input  logic [fsip_pkg::ArgW-1:0]         in_arg_value,
  input  fsip_pkg::cmd_t                    cmd,
  output fsip_pkg::sts_t                    sts,
  output logic [fsip_pkg::CharW-1:0]        out_char,
  output logic                              out_last
);
  import fsip_pkg::*;

  logic [CharW-1:0]  ch_r;
  logic [ArgW-1:0]   arg_r;
  logic [WordW-1:0]  bin_r;
  logic [BcdW-1:0]   bcd_r;
  logic [StepW-1:0]  cnt_r;
  logic [ArgW-1:0]   nib_r;
  logic [NleftW-1:0] nleft_r;
  logic [CharW-1:0]  out_char_r;
  logic              out_last_r;

  logic [WordW-1:0]  w;
  logic [BcdW-1:0]   bcd_adj;
  logic [ArgW-1:0]   oct_nib;
  logic [WordW:0]    w_ext;
  logic [ArgW-1:0]   nib_nxt;
  logic [CharW-1:0]  char_nxt;
  kind_t             kind;

  assign w     = arg_r[WordW-1:0];
  assign w_ext = {1'b0, w};

  always_comb begin
    unique case (ch_r)
      CHAR_NUL:  kind = K_NUL;
      CHAR_PCT:  kind = K_PCT;
      CHAR_C_LC: kind = K_C;
      CHAR_D_LC: kind = K_D;
      CHAR_O_LC: kind = K_O;
      CHAR_U_LC: kind = K_U;
      CHAR_X_LC: kind = K_X;
      CHAR_P_LC: kind = K_P;
      default:   kind = K_OTHER;
    endcase
  end

  // double-dabble correction per bcd digit
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (bcd_r[i*NibW +: NibW] >= 4'd5) begin
        bcd_adj[i*NibW +: NibW] = bcd_r[i*NibW +: NibW] + 4'd3;
      end else begin
        bcd_adj[i*NibW +: NibW] = bcd_r[i*NibW +: NibW];
      end
    end
  end

  always_comb begin
    oct_nib = '0;
    for (int i = 0; i < OctDigits; i++) begin
      oct_nib[i*NibW +: NibW] = {1'b0, w_ext[i*3 +: 3]};
    end
  end

  always_comb begin
    unique case (cmd.nib_src)
      LD_HEX64: nib_nxt = arg_r;
      LD_HEX32: nib_nxt = {{(ArgW-WordW){1'b0}}, w};
      LD_OCT:   nib_nxt = oct_nib;
      LD_BCD:   nib_nxt = {{(ArgW-BcdW){1'b0}}, bcd_r};
    endcase
  end

  always_comb begin
    unique case (cmd.out_sel)
      SEL_CH:    char_nxt = ch_r;
      SEL_ARG:   char_nxt = arg_r[CharW-1:0];
      SEL_MINUS: char_nxt = CHAR_MINUS;
      SEL_ZERO:  char_nxt = CHAR_0;
      SEL_X:     char_nxt = CHAR_X_LC;
      SEL_DIGIT: char_nxt = digit_char(nib_r[ArgW-1 -: NibW]);
      default:   char_nxt = CHAR_0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ch_r  <= in_fmt_char;
      arg_r <= in_arg_value;
    end
    if (cmd.dec_start) begin
      bin_r <= (kind == K_D && w[WordW-1]) ? (~w + 1'b1) : w;
      bcd_r <= '0;
      cnt_r <= '0;
    end else if (cmd.dec_step) begin
      bcd_r <= {bcd_adj[BcdW-2:0], bin_r[WordW-1]};
      bin_r <= {bin_r[WordW-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.nib_load) begin
      nib_r   <= nib_nxt;
      nleft_r <= NleftW'(NibCnt);
    end else if (cmd.shift) begin
      nib_r   <= {nib_r[ArgW-NibW-1:0], {NibW{1'b0}}};
      nleft_r <= nleft_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_char_r <= char_nxt;
      out_last_r <= cmd.out_last;
    end
  end

  assign sts.kind      = kind;
  assign sts.neg       = w[WordW-1];
  assign sts.top_zero  = (nib_r[ArgW-1 -: NibW] == '0);
  assign sts.nleft_one = (nleft_r == NleftW'(1));
  assign sts.dec_done  = (cnt_r == StepW'(WordW - 1));

  assign out_char = out_char_r;
  assign out_last = out_last_r;

endmodule

FILE: design/fsip_ctrl.sv
module fsip_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fsip_pkg::sts_t  sts,
  output fsip_pkg::cmd_t  cmd
);
  import fsip_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_MINUS, S_DEC, S_BCD, S_ZERO, S_XCHR, S_SKIP, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   pending_r, pending_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    pending_nxt = pending_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!pending_r) begin
          priority if (sts.kind == K_PCT) begin
            pending_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end else if (sts.kind == K_NUL) begin
            state_nxt = S_IDLE;
          end else begin
            if (out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = SEL_CH;
              cmd.out_last = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        end else begin
          unique case (sts.kind)
            K_C: begin
              if (out_free) begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = SEL_ARG;
                cmd.out_last = 1'b1;
                pending_nxt  = 1'b0;
                state_nxt    = S_IDLE;
              end
            end
            K_D: begin
              cmd.dec_start = 1'b1;
              pending_nxt   = 1'b0;
              state_nxt     = sts.neg ? S_MINUS : S_DEC;
            end
            K_U: begin
              cmd.dec_start = 1'b1;
              pending_nxt   = 1'b0;
              state_nxt     = S_DEC;
            end
            K_O: begin
              cmd.nib_load = 1'b1;
              cmd.nib_src  = LD_OCT;
              pending_nxt  = 1'b0;
              state_nxt    = S_SKIP;
            end
            K_X: begin
              cmd.nib_load = 1'b1;
              cmd.nib_src  = LD_HEX32;
              pending_nxt  = 1'b0;
              state_nxt    = S_SKIP;
            end
            K_P: begin
              cmd.nib_load = 1'b1;
              cmd.nib_src  = LD_HEX64;
              pending_nxt  = 1'b0;
              state_nxt    = S_ZERO;
            end
            default: begin
              pending_nxt = 1'b0;
              state_nxt   = S_IDLE;
            end
          endcase
        end
      end
      S_MINUS: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_MINUS;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec_step = 1'b1;
        if (sts.dec_done) begin
          state_nxt = S_BCD;
        end
      end
      S_BCD: begin
        cmd.nib_load = 1'b1;
        cmd.nib_src  = LD_BCD;
        state_nxt    = S_SKIP;
      end
      S_ZERO: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_ZERO;
          state_nxt    = S_XCHR;
        end
      end
      S_XCHR: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_X;
          state_nxt    = S_SKIP;
        end
      end
      S_SKIP: begin
        if (sts.top_zero && !sts.nleft_one) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_DIGIT;
          cmd.out_last = sts.nleft_one;
          cmd.shift    = 1'b1;
          if (sts.nleft_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_acc_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_DISPATCH)
    else $error("accepted item not dispatched");

  a_dec_runs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DEC && !sts.dec_done |=> state_r == S_DEC)
    else $error("decimal conversion cut short");

  a_pending_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pending_r) |-> $past(state_r) == S_DISPATCH && $past(sts.kind) == K_PCT)
    else $error("pending flag set without percent");

endmodule

FILE: design/format_string_integer_printer.sv
// Integer printf engine: each input item is one format byte with an argument word.
// Plain bytes pass through, a percent arms the next byte as a conversion (c, d, o, u,
// x, p); unknown conversions and NUL emit nothing. Output bytes leave one per cycle
// while the receiver is ready, through a registered output stage, and last marks the
// final byte of an item. Items are handled one at a time: the input is not ready again
// until an item is done. %x and %o run a 16-nibble scan that skips leading zeros one
// per cycle, then print; %p does the same after its 0x prefix; %u and %d first run the
// shift-and-add-3 binary to BCD loop, and a negative %d first prints a minus sign.
// Output back-pressure can stall any item.
module format_string_integer_printer (
  input  logic        clk,
  input  logic        rst_n,
  fsip_in_if.sink     in_chan,
  fsip_out_if.source  out_chan
);
  import fsip_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fsip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsip_dp u_dp (
    .clk          (clk),
    .in_fmt_char  (in_chan.fmt_char),
    .in_arg_value (in_chan.arg_value),
    .cmd          (cmd),
    .sts          (sts),
    .out_char     (out_chan.out_char),
    .out_last     (out_chan.last)
  );

endmodule
